@@ rtl/tdmasc_pkg.sv @@
// Shared types, codes and sizes for the TDMA seat membership controller.
package tdmasc_pkg;

	localparam int SEATS_DEF = 32;
	localparam int SEAT_W    = 5;
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int TS_W      = 40;
	localparam int DLY_W     = 7;

	localparam logic [1:0] CMD_BEACON  = 2'd0;
	localparam logic [1:0] CMD_JOIN    = 2'd1;
	localparam logic [1:0] CMD_CONFIRM = 2'd2;
	localparam logic [1:0] CMD_TICK    = 2'd3;

	localparam logic [2:0] ACT_REARM   = 3'd0;
	localparam logic [2:0] ACT_REPLY   = 3'd1;
	localparam logic [2:0] ACT_REQUEST = 3'd2;
	localparam logic [2:0] ACT_CONFIRM = 3'd3;
	localparam logic [2:0] ACT_BEACON  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ROLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANT     = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_CALC,
		ST_ADD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_map;
		logic grant;
		logic refresh;
		logic tick;
		logic scan_load;
		logic scan_shift;
	} cell_ctl_t;

endpackage

@@ rtl/tdmasc_cell.sv @@
// One seat cell: occupancy bit, timeout counter and a scan stage of the chain.
module tdmasc_cell #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdmasc_pkg::cell_ctl_t ctl,
	input  logic [4:0]            seat,
	input  logic                  map_bit,
	input  logic [7:0]            limit,
	input  logic                  scan_in,
	output logic                  occ,
	output logic                  scan_out
);

	logic       occ_q;
	logic [7:0] tmo_q;
	logic       scan_q;
	logic       sel;

	assign sel      = (seat == 5'(IDX));
	assign occ      = occ_q;
	assign scan_out = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= (IDX == 0);
			tmo_q  <= '0;
			scan_q <= 1'b0;
		end else begin
			if (ctl.load_map) begin
				occ_q <= map_bit;
			end
			if (ctl.grant && sel) begin
				occ_q <= 1'b1;
				tmo_q <= limit;
			end
			if (ctl.refresh && sel) begin
				tmo_q <= limit;
			end
			if (ctl.tick && (IDX != 0) && occ_q) begin
				if (tmo_q == 8'd0) begin
					occ_q <= 1'b0;
				end else begin
					tmo_q <= tmo_q - 8'd1;
				end
			end
			if (ctl.scan_load) begin
				scan_q <= occ_q;
			end else if (ctl.scan_shift) begin
				scan_q <= scan_in;
			end
		end
	end

endmodule

@@ rtl/tdma_seat_membership_controller.sv @@
// Top level of the TDMA seat membership controller.
// Usage:
//   Input channel (in_valid/in_stall) carries one decoded frame or a round
//   tick; the output channel (out_valid/out_stall) returns exactly one
//   result per input item. Configuration is written on cfg_we with
//   cfg_index/cfg_data while the block is idle.
//   Seat state lives in a chain of SEATS cells; occupant count and lowest
//   free seat come from shifting the occupancy down the chain one seat a
//   cycle into a counter at cell zero.
//   Sequence: a frame that needs no recount passes through FIN into the output
//   register. A round tick at the initiator passes through LOAD, SCAN and FIN
//   (recount scan). A responder beacon on seat zero passes through LOAD, SCAN,
//   CALC, ADD and FIN (scan, slot multiply, add).
//   Flow: one item at a time; in_stall is high while an item is at work.
//   A stalled result holds in the output register; the finishing step waits
//   for that register to drain before the next result is written.
//   Reset: seat zero occupied, count 1, all counters zero, registers at
//   their default values. No clearing pass is needed.
module tdma_seat_membership_controller #(
	parameter int SEATS = tdmasc_pkg::SEATS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] frame_src,
	input  logic [15:0] frame_dst,
	input  logic [4:0]  seat,
	input  logic [31:0] seat_map_in,
	input  logic [7:0]  seq_num,
	input  logic [39:0] rx_timestamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [31:0] tx_time,
	output logic [39:0] tx_timestamp,
	output logic [31:0] rx_ts_echo,
	output logic [15:0] dest_out,
	output logic [4:0]  seat_out,
	output logic [31:0] seat_map_out,
	output logic [5:0]  device_count,
	output logic [7:0]  seq_out,
	output logic        joined_out
);

	localparam int SW   = (SEATS > 1) ? $clog2(SEATS) : 1;
	localparam int HALF = SEATS / 2;

	tdmasc_pkg::state_t    state_q, state_n;
	tdmasc_pkg::cell_ctl_t ctl;

	logic        role_q;
	logic [15:0] own_q;
	logic [7:0]  limit_q;
	logic [31:0] slot_q;
	logic [15:0] ant_q;

	logic [4:0]  local_q;
	logic        joined_q;
	logic [7:0]  seq_q;
	logic [15:0] init_q;
	logic [39:0] brx_q;
	logic [5:0]  count_q;

	logic [2:0]  res_act_q;
	logic [15:0] res_dest_q;
	logic [4:0]  res_seat_q;
	logic        seat_ov_q;
	logic        pre_q;
	logic [31:0] res_map_q;
	logic [5:0]  res_cnt_q;
	logic [7:0]  res_seq_q;
	logic [31:0] res_tx_q;
	logic        send_q;
	logic        bcn0_q;
	logic [31:0] prod_s1;

	logic [SW-1:0] idx_q;
	logic [5:0]    acc_q;
	logic          found_q;
	logic [4:0]    free_q;

	logic        out_valid_q;
	logic [2:0]  action_q;
	logic [31:0] tx_time_q;
	logic [39:0] tx_ts_q;
	logic [31:0] echo_q;
	logic [15:0] dest_q;
	logic [4:0]  seat_o_q;
	logic [31:0] map_o_q;
	logic [5:0]  cnt_o_q;
	logic [7:0]  seq_o_q;
	logic        joined_o_q;

	logic [SEATS-1:0] occ_vec;
	logic [SEATS:0]   scan_chain;

	logic accept, seat_ok, is_tick, is_bcn_i, is_bcn_r, is_join, is_conf, need_scan;
	logic scan_last, fin_go, scan_bit, send_c;
	logic [6:0] delay_c;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != tdmasc_pkg::ST_IDLE);
	assign seat_ok   = ({1'b0, seat} < 6'(SEATS));
	assign is_tick   = (command == tdmasc_pkg::CMD_TICK) && !role_q;
	assign is_bcn_i  = (command == tdmasc_pkg::CMD_BEACON) && seat_ok && !role_q;
	assign is_bcn_r  = (command == tdmasc_pkg::CMD_BEACON) && seat_ok && role_q;
	assign is_join   = (command == tdmasc_pkg::CMD_JOIN) && seat_ok && !role_q
		&& !occ_vec[seat[SW-1:0]];
	assign is_conf   = (command == tdmasc_pkg::CMD_CONFIRM) && seat_ok && role_q
		&& (frame_dst == own_q);
	assign need_scan = is_tick || (is_bcn_r && (seat == 5'd0));
	assign scan_last = (idx_q == SW'(SEATS - 1));
	assign scan_bit  = scan_chain[0];
	assign fin_go    = (state_q == tdmasc_pkg::ST_FIN) && (!out_valid_q || !out_stall);

	assign scan_chain[SEATS] = 1'b0;

	for (genvar i = 0; i < SEATS; i++) begin : g_cell
		tdmasc_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.seat     (seat),
			.map_bit  (seat_map_in[i]),
			.limit    (limit_q),
			.scan_in  (scan_chain[i+1]),
			.occ      (occ_vec[i]),
			.scan_out (scan_chain[i])
		);
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			tdmasc_pkg::ST_IDLE: begin
				if (accept) state_n = need_scan ? tdmasc_pkg::ST_LOAD : tdmasc_pkg::ST_FIN;
			end
			tdmasc_pkg::ST_LOAD: state_n = tdmasc_pkg::ST_SCAN;
			tdmasc_pkg::ST_SCAN: begin
				if (scan_last) state_n = bcn0_q ? tdmasc_pkg::ST_CALC : tdmasc_pkg::ST_FIN;
			end
			tdmasc_pkg::ST_CALC: state_n = tdmasc_pkg::ST_ADD;
			tdmasc_pkg::ST_ADD:  state_n = tdmasc_pkg::ST_FIN;
			tdmasc_pkg::ST_FIN: begin
				if (fin_go) state_n = tdmasc_pkg::ST_IDLE;
			end
			default: state_n = tdmasc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.load_map   = accept && is_bcn_r && (seat == 5'd0);
		ctl.grant      = accept && is_join;
		ctl.refresh    = accept && is_bcn_i;
		ctl.tick       = accept && is_tick;
		ctl.scan_load  = (state_q == tdmasc_pkg::ST_LOAD);
		ctl.scan_shift = (state_q == tdmasc_pkg::ST_SCAN);
	end

	always_comb begin
		send_c  = 1'b1;
		delay_c = {1'b0, local_q, 1'b0};
		if (count_q > 6'(HALF)) begin
			if (!seq_q[0] && (local_q < 5'(HALF))) begin
				delay_c = {1'b0, local_q, 1'b0};
			end else if (seq_q[0] && (local_q >= 5'(HALF))) begin
				delay_c = 7'(({2'b0, local_q} - 7'(HALF) + 7'd1) << 1);
			end else begin
				send_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdmasc_pkg::ST_IDLE;
			role_q      <= 1'b0;
			own_q       <= '0;
			limit_q     <= 8'd10;
			slot_q      <= 32'd65536000;
			ant_q       <= 16'd16436;
			local_q     <= '0;
			joined_q    <= 1'b0;
			seq_q       <= '0;
			init_q      <= '0;
			brx_q       <= '0;
			count_q     <= 6'd1;
			res_act_q   <= tdmasc_pkg::ACT_REARM;
			res_dest_q  <= '0;
			res_seat_q  <= '0;
			seat_ov_q   <= 1'b0;
			pre_q       <= 1'b0;
			res_map_q   <= '0;
			res_cnt_q   <= '0;
			res_seq_q   <= '0;
			res_tx_q    <= '0;
			send_q      <= 1'b0;
			bcn0_q      <= 1'b0;
			prod_s1     <= '0;
			idx_q       <= '0;
			acc_q       <= '0;
			found_q     <= 1'b0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
			action_q    <= '0;
			tx_time_q   <= '0;
			tx_ts_q     <= '0;
			echo_q      <= '0;
			dest_q      <= '0;
			seat_o_q    <= '0;
			map_o_q     <= '0;
			cnt_o_q     <= '0;
			seq_o_q     <= '0;
			joined_o_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				case (cfg_index)
					tdmasc_pkg::REG_ROLE:    role_q  <= cfg_data[0];
					tdmasc_pkg::REG_ADDR:    own_q   <= cfg_data[15:0];
					tdmasc_pkg::REG_TIMEOUT: limit_q <= cfg_data[7:0];
					tdmasc_pkg::REG_SLOT:    slot_q  <= cfg_data;
					tdmasc_pkg::REG_ANT:     ant_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (accept) begin
				res_act_q  <= tdmasc_pkg::ACT_REARM;
				res_dest_q <= '0;
				res_tx_q   <= '0;
				send_q     <= 1'b0;
				seat_ov_q  <= 1'b0;
				pre_q      <= 1'b0;
				bcn0_q     <= is_bcn_r && (seat == 5'd0);
				if (is_tick) begin
					res_act_q  <= tdmasc_pkg::ACT_BEACON;
					res_dest_q <= 16'hFFFF;
					pre_q      <= 1'b1;
					res_map_q  <= 32'(occ_vec);
					res_cnt_q  <= count_q;
					res_seq_q  <= seq_q;
					seq_q      <= seq_q + 8'd1;
				end
				if (is_bcn_r) begin
					if ((seat == local_q) || ((seat == 5'd0)
						&& ((seat_map_in & 32'({SEATS{1'b1}})) == 32'd1))) begin
						joined_q <= 1'b0;
					end
					if (seat == 5'd0) begin
						brx_q  <= rx_timestamp;
						seq_q  <= seq_num;
						init_q <= frame_src;
					end
				end
				if (is_join) begin
					count_q    <= count_q + 6'd1;
					res_act_q  <= tdmasc_pkg::ACT_CONFIRM;
					res_dest_q <= frame_src;
					res_seat_q <= seat;
					seat_ov_q  <= 1'b1;
				end
				if (is_conf) begin
					local_q  <= seat;
					joined_q <= 1'b1;
				end
			end
			if (state_q == tdmasc_pkg::ST_LOAD) begin
				idx_q   <= '0;
				acc_q   <= '0;
				found_q <= 1'b0;
				free_q  <= '0;
			end
			if (state_q == tdmasc_pkg::ST_SCAN) begin
				idx_q <= idx_q + SW'(1);
				acc_q <= acc_q + 6'(scan_bit);
				if (!scan_bit && !found_q) begin
					found_q <= 1'b1;
					free_q  <= 5'(idx_q);
				end
				if (scan_last) count_q <= acc_q + 6'(scan_bit);
			end
			if (state_q == tdmasc_pkg::ST_CALC) begin
				if (joined_q) begin
					send_q  <= send_c;
					prod_s1 <= 32'(delay_c * slot_q);
				end else if (found_q) begin
					local_q    <= free_q;
					res_act_q  <= tdmasc_pkg::ACT_REQUEST;
					res_dest_q <= init_q;
				end
			end
			if ((state_q == tdmasc_pkg::ST_ADD) && send_q) begin
				res_tx_q   <= 32'((41'(brx_q) + 41'(prod_s1)) >> 8);
				res_act_q  <= tdmasc_pkg::ACT_REPLY;
				res_dest_q <= 16'hFFFF;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
				action_q    <= res_act_q;
				tx_time_q   <= res_tx_q;
				tx_ts_q     <= (res_act_q == tdmasc_pkg::ACT_REPLY)
					? ({res_tx_q[31:1], 1'b0, 8'd0} + {24'd0, ant_q}) : 40'd0;
				echo_q      <= brx_q[31:0];
				dest_q      <= res_dest_q;
				seat_o_q    <= seat_ov_q ? res_seat_q : local_q;
				map_o_q     <= pre_q ? res_map_q : 32'(occ_vec);
				cnt_o_q     <= pre_q ? res_cnt_q : count_q;
				seq_o_q     <= pre_q ? res_seq_q : seq_q;
				joined_o_q  <= joined_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign tx_time      = tx_time_q;
	assign tx_timestamp = tx_ts_q;
	assign rx_ts_echo   = echo_q;
	assign dest_out     = dest_q;
	assign seat_out     = seat_o_q;
	assign seat_map_out = map_o_q;
	assign device_count = cnt_o_q;
	assign seq_out      = seq_o_q;
	assign joined_out   = joined_o_q;

endmodule

@@ rtl/tdmasc_chk.sv @@
// Port-level checks for the TDMA seat membership controller, bound to the top.
module tdmasc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  action,
	input logic [15:0] dest_out,
	input logic [31:0] tx_time
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action))
		else $error("result dropped while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action == tdmasc_pkg::ACT_REARM || action == tdmasc_pkg::ACT_REPLY
			|| action == tdmasc_pkg::ACT_REQUEST || action == tdmasc_pkg::ACT_CONFIRM
			|| action == tdmasc_pkg::ACT_BEACON))
		else $error("action code out of range");

	a_bcast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == tdmasc_pkg::ACT_REPLY || action == tdmasc_pkg::ACT_BEACON)
			|-> dest_out == 16'hFFFF)
		else $error("beacon not broadcast");

	a_txtime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != tdmasc_pkg::ACT_REPLY |-> tx_time == 32'd0)
		else $error("transmit time set without delayed reply");

endmodule

bind tdma_seat_membership_controller tdmasc_chk u_chk (.*);
